[sv/gsd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, sizes and grid mirror functions for the grid symmetry dedup table.
// No dependencies; every other file imports this package.
package gsd_pkg;

    localparam int ROWS          = 3;
    localparam int COLS          = 5;
    localparam int TABLE_ENTRIES = 4096;

    localparam int FIELD_CELLS = 15;
    localparam int GRID_W      = 2 * FIELD_CELLS;
    localparam int GRID_CELLS  = ROWS * COLS;
    localparam int CNT_W       = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int STORED_W    = 13;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [GRID_W-1:0]   t_grid;
    typedef logic [CNT_W-1:0]    t_count;
    typedef logic [STORED_W-1:0] t_stored;

    // One classified beat handed from the front end to the scan engine.
    typedef struct packed {
        logic  clear;
        t_grid grid;
        t_grid lr;
        t_grid ud;
        t_grid rot;
    } t_cmd;

    // Cells at or beyond the grid size are dropped.
    function automatic t_grid trim_grid(t_grid g);
        t_grid out;
        out = g;
        for (int i = 0; i < FIELD_CELLS; i++) begin
            if (i >= GRID_CELLS) begin
                out[2*i +: 2] = 2'b00;
            end
        end
        return out;
    endfunction

    // Pure rewiring: rows and/or columns reversed; cells outside the word read as zero.
    function automatic t_grid image_of(t_grid g, logic flip_rows, logic flip_cols);
        t_grid out;
        int    sr;
        int    sc;
        int    src;
        int    dst;
        out = '0;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                sr  = flip_rows ? (ROWS - 1 - r) : r;
                sc  = flip_cols ? (COLS - 1 - c) : c;
                src = sr * COLS + sc;
                dst = r * COLS + c;
                if (dst < FIELD_CELLS && src < FIELD_CELLS) begin
                    out[2*dst +: 2] = g[2*src +: 2];
                end
            end
        end
        return out;
    endfunction

endpackage

[sv/gsd_ifaces.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input grids, results, and internal command beats.
// Depends on gsd_pkg.
interface gsd_in_if;
    import gsd_pkg::*;
    logic  valid;
    logic  ready;
    t_grid grid_cells;
    logic  clear_first;
    modport source (output valid, output grid_cells, output clear_first, input ready);
    modport sink (input valid, input grid_cells, input clear_first, output ready);
endinterface

interface gsd_out_if;
    import gsd_pkg::*;
    logic    valid;
    logic    ready;
    logic    is_new;
    t_stored stored_count;
    logic    table_full;
    modport source (output valid, output is_new, output stored_count, output table_full,
                    input ready);
    modport sink (input valid, input is_new, input stored_count, input table_full,
                  output ready);
endinterface

interface gsd_cmd_if;
    import gsd_pkg::*;
    logic valid;
    logic ready;
    t_cmd cmd;
    modport source (output valid, output cmd, input ready);
    modport sink (input valid, input cmd, output ready);
endinterface

[sv/gsd_front.sv]
`timescale 1ns / 1ps
// Front end: accepts grid beats, trims them and forms the three mirror images.
// Depends on gsd_pkg and gsd_ifaces.
module gsd_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gsd_in_if.sink       i_in,
    gsd_cmd_if.source    o_cmd
);
    import gsd_pkg::*;

    logic  r_valid;
    t_cmd  r_cmd;
    t_grid trimmed;

    assign trimmed    = trim_grid(i_in.grid_cells);
    assign i_in.ready = !r_valid || o_cmd.ready;
    assign o_cmd.valid = r_valid;
    assign o_cmd.cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (o_cmd.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd.clear <= i_in.clear_first;
            r_cmd.grid  <= trimmed;
            r_cmd.lr    <= image_of(trimmed, 1'b0, 1'b1);
            r_cmd.ud    <= image_of(trimmed, 1'b1, 1'b0);
            r_cmd.rot   <= image_of(trimmed, 1'b1, 1'b1);
        end
    end

endmodule

[sv/gsd_queue.sv]
`timescale 1ns / 1ps
// Short FIFO of command beats between the front end and the scan engine.
// Depends on gsd_pkg and gsd_ifaces.
module gsd_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gsd_cmd_if.sink    i_cmd,
    gsd_cmd_if.source  o_cmd
);
    import gsd_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_fill;
    logic              push;
    logic              pop;

    assign i_cmd.ready = (r_fill != QCNT_W'(QUEUE_DEPTH));
    assign o_cmd.valid = (r_fill != '0);
    assign o_cmd.cmd   = r_slot[r_rd_ptr];
    assign push        = i_cmd.valid && i_cmd.ready;
    assign pop         = o_cmd.valid && o_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_cmd.cmd;
        end
    end

endmodule

[sv/gsd_back.sv]
`timescale 1ns / 1ps
// Scan engine: walks the grid table one entry per cycle, appends new grids, drives results.
// Depends on gsd_pkg and gsd_ifaces.
module gsd_back (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gsd_cmd_if.sink     i_cmd,
    gsd_out_if.source   o_out
);
    import gsd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    localparam t_count TE_CNT = CNT_W'(TABLE_ENTRIES);

    t_state  r_state;
    t_count  r_count;
    t_count  r_issue;
    logic    r_pend;
    logic    r_hit;
    t_grid   r_grid;
    t_grid   r_lr;
    t_grid   r_ud;
    t_grid   r_rot;
    t_grid   r_rd_data;
    t_grid   r_mem [TABLE_ENTRIES];

    logic    r_out_valid;
    logic    r_out_new;
    t_stored r_out_stored;
    logic    r_out_full;

    logic    hit_now;
    logic    rd_en;
    logic    out_free;
    logic    room;
    logic    wr_en;

    assign i_cmd.ready        = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.is_new       = r_out_new;
    assign o_out.stored_count = r_out_stored;
    assign o_out.table_full   = r_out_full;

    assign hit_now  = r_pend && (r_rd_data == r_lr || r_rd_data == r_ud
                                 || r_rd_data == r_rot);
    assign rd_en    = (r_state == S_SCAN) && !hit_now && (r_issue < r_count);
    assign out_free = !r_out_valid || o_out.ready;
    assign room     = (r_count < TE_CNT);
    assign wr_en    = (r_state == S_DONE) && out_free && !r_hit && room;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_issue[ADDR_W-1:0]];
        end
        if (wr_en) begin
            r_mem[r_count[ADDR_W-1:0]] <= r_grid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_issue     <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In S_DONE a free result register is reloaded below instead.
            if (r_out_valid && o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_grid  <= i_cmd.cmd.grid;
                        r_lr    <= i_cmd.cmd.lr;
                        r_ud    <= i_cmd.cmd.ud;
                        r_rot   <= i_cmd.cmd.rot;
                        r_issue <= '0;
                        r_pend  <= 1'b0;
                        r_hit   <= 1'b0;
                        if (i_cmd.cmd.clear) begin
                            r_count <= '0;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // One read in flight; its data is checked the cycle after issue.
                    if (hit_now) begin
                        r_hit   <= 1'b1;
                        r_pend  <= 1'b0;
                        r_state <= S_DONE;
                    end else if (rd_en) begin
                        r_issue <= r_issue + 1'b1;
                        r_pend  <= 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_new   <= !r_hit;
                        r_out_full  <= !r_hit && !room;
                        if (wr_en) begin
                            r_count      <= r_count + 1'b1;
                            r_out_stored <= STORED_W'(r_count + 1'b1);
                        end else begin
                            r_out_stored <= STORED_W'(r_count);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/grid_symmetry_dedup_table.sv]
`timescale 1ns / 1ps
// Top level of the grid symmetry dedup table: front end, command queue and scan engine.
// Depends on gsd_pkg, gsd_ifaces, gsd_front, gsd_queue and gsd_back.
//
// Each input beat carries one ROWS x COLS grid of 2-bit cells. The block compares its
// left-right mirror, up-down mirror and 180-degree turn against every stored grid; if
// none matches, the unmirrored grid is appended and the result reports it as new. A set
// clear_first empties the table before the check. When the table already holds
// TABLE_ENTRIES grids a new grid is dropped and table_full is set. The scan engine
// reads the table memory one entry per clock over the N grids held when an item starts
// (up to TABLE_ENTRIES), and stops early at the first match. The front end and a
// two-deep queue keep taking beats while a scan runs, and the result register frees
// the engine from a stalled consumer.
// No clearing pass is needed after reset: entries above the fill count are never read.
module grid_symmetry_dedup_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gsd_in_if.sink      i_in,
    gsd_out_if.source   o_out
);
    import gsd_pkg::*;

    gsd_cmd_if front_cmd ();
    gsd_cmd_if queue_cmd ();

    gsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_cmd   (front_cmd.source)
    );

    gsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (front_cmd.sink),
        .o_cmd   (queue_cmd.source)
    );

    gsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (queue_cmd.sink),
        .o_out   (o_out)
    );

endmodule

[sv/gsd_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the result channel of the grid symmetry dedup table.
// Depends on gsd_pkg; bound to grid_symmetry_dedup_table below.
module gsd_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic                    i_is_new,
    input gsd_pkg::t_stored        i_stored_count,
    input logic                    i_table_full
);
    import gsd_pkg::*;

    localparam t_stored FULL_CNT = STORED_W'(TABLE_ENTRIES);

    // No result may appear in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat withdrawn while stalled");

    // A dropped grid is always a new one.
    a_full_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_table_full |-> i_is_new)
        else $error("table_full without is_new");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_table_full |-> i_stored_count == FULL_CNT)
        else $error("table_full with a count below capacity");

endmodule

bind grid_symmetry_dedup_table gsd_checker u_gsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_is_new       (o_out.is_new),
    .i_stored_count (o_out.stored_count),
    .i_table_full   (o_out.table_full)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for grid_symmetry_dedup_table: drives grids, predicts the
// new/count/full verdict for each one and checks every result beat in order.
// Depends on gsd_pkg, gsd_ifaces and the RTL under sv/.
module tb_top;
    import gsd_pkg::*;

    localparam int QUIET_LIMIT = 4 * (TABLE_ENTRIES + 64);

    typedef struct packed {
        logic    is_new;
        t_stored stored_count;
        logic    table_full;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gsd_in_if  grid_in ();
    gsd_out_if verdict_out ();

    grid_symmetry_dedup_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (grid_in),
        .o_out   (verdict_out)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state: multiset of held grids plus the fill count.
    int unsigned held_grids[t_grid];
    int unsigned held_total;
    t_verdict    verdicts_due[$];
    t_grid       sent_log[$];

    int          pace_max;
    bit          feeding;
    int unsigned quiet_cycles;
    int unsigned errors;
    int unsigned grids_sent;
    int unsigned verdicts_seen;
    int unsigned drops_seen;
    int unsigned clears_sent;

    // Cells at or past ROWS*COLS carry nothing.
    function automatic t_grid keep_cells(t_grid g);
        t_grid k;
        k = g;
        for (int i = ROWS * COLS; i < FIELD_CELLS; i++) begin
            k[2*i +: 2] = 2'b00;
        end
        return k;
    endfunction

    function automatic t_grid mirror_grid(t_grid g, bit flip_rows, bit flip_cols);
        t_grid m;
        int    src;
        int    dst;
        m = '0;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                src = (flip_rows ? ROWS - 1 - r : r) * COLS + (flip_cols ? COLS - 1 - c : c);
                dst = r * COLS + c;
                if (dst < FIELD_CELLS && src < FIELD_CELLS) begin
                    m[2*dst +: 2] = g[2*src +: 2];
                end
            end
        end
        return m;
    endfunction

    // Only the three mirrors are looked up, never the grid itself.
    function automatic void classify_grid(t_grid raw, logic clr);
        t_grid    g;
        t_grid    lr;
        t_grid    ud;
        t_grid    rot;
        logic     hit;
        t_verdict v;
        g = keep_cells(raw);
        if (clr) begin
            held_grids.delete();
            held_total = 0;
        end
        lr  = mirror_grid(g, 1'b0, 1'b1);
        ud  = mirror_grid(g, 1'b1, 1'b0);
        rot = mirror_grid(g, 1'b1, 1'b1);
        hit = held_grids.exists(lr) || held_grids.exists(ud) || held_grids.exists(rot);
        v.table_full = 1'b0;
        if (!hit) begin
            if (held_total < TABLE_ENTRIES) begin
                if (held_grids.exists(g)) begin
                    held_grids[g]++;
                end else begin
                    held_grids[g] = 1;
                end
                held_total++;
            end else begin
                v.table_full = 1'b1;
            end
        end
        v.is_new       = !hit;
        v.stored_count = t_stored'(held_total);
        verdicts_due   = {verdicts_due, v};
    endfunction

    function automatic t_grid fresh_cells(bit allow_three);
        t_grid g;
        g = '0;
        for (int i = 0; i < ROWS * COLS && i < FIELD_CELLS; i++) begin
            g[2*i +: 2] = 2'($urandom_range(0, allow_three ? 3 : 2));
        end
        return g;
    endfunction

    task automatic offer_grid(t_grid g, logic clr);
        int gap;
        gap = $urandom_range(0, pace_max);
        // valid stays up across back-to-back beats; a gap lowers it until the next beat
        if (gap > 0 || !feeding) begin
            if (feeding) begin
                grid_in.valid <= 1'b0;
            end
            feeding = 1'b0;
            repeat ((gap > 0) ? gap : 1) @(posedge i_clk);
        end
        grid_in.valid       <= 1'b1;
        grid_in.grid_cells  <= g;
        grid_in.clear_first <= clr;
        feeding = 1'b1;
        do @(posedge i_clk); while (!(grid_in.valid && grid_in.ready));
        classify_grid(g, clr);
        sent_log = {sent_log, keep_cells(g)};
        grids_sent++;
        if (clr) begin
            clears_sent++;
        end
    endtask

    task automatic settle_verdicts();
        if (feeding) begin
            grid_in.valid <= 1'b0;
        end
        feeding = 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_extremes();
        pace_max = 6;
        offer_grid(30'h0000_0000, 1'b1);    // empty grid, symmetric
        offer_grid(30'h0000_0000, 1'b0);    // now matches itself
        offer_grid(30'h3FFF_FFFF, 1'b0);    // every cell three
        offer_grid(30'h2AAA_AAAA, 1'b0);
        offer_grid(30'h1555_5555, 1'b0);
        offer_grid(30'h3FFF_FFFF, 1'b0);
        offer_grid(30'h1234_5678, 1'b0);
    endtask

    // Asymmetric grid: a second copy is stored, any mirror of it is a hit.
    task automatic test_identity_skipped();
        t_grid a;
        a = 30'h0000_0001;
        offer_grid(a, 1'b1);
        offer_grid(a, 1'b0);
        offer_grid(mirror_grid(a, 1'b0, 1'b1), 1'b0);
        offer_grid(mirror_grid(a, 1'b1, 1'b0), 1'b0);
        offer_grid(mirror_grid(a, 1'b1, 1'b1), 1'b0);
    endtask

    task automatic test_cell_three();
        t_grid t;
        t = 30'h0000_00CF;
        offer_grid(t, 1'b0);
        offer_grid(mirror_grid(t, 1'b1, 1'b1), 1'b0);
        offer_grid(30'h3000_0003, 1'b0);
    endtask

    // Clear beat whose grid would otherwise have matched.
    task automatic test_clear_with_grid();
        offer_grid(mirror_grid(30'h0000_0001, 1'b0, 1'b1), 1'b1);
        offer_grid(30'h0000_0001, 1'b0);
        offer_grid(30'h0000_0001, 1'b1);
        settle_verdicts();
    endtask

    task automatic test_random_mix();
        int    pick;
        t_grid g;
        for (int n = 0; n < 120; n++) begin
            pace_max = ((n / 35) % 2 == 0) ? 6 : 0;
            if (n == 70) begin
                settle_verdicts();
            end
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
                g = fresh_cells(1'b0);
            end else if (pick < 15 && sent_log.size() != 0) begin
                g = mirror_grid(sent_log[$urandom_range(0, sent_log.size() - 1)],
                                $urandom_range(0, 1), $urandom_range(0, 1));
            end else if (pick < 17) begin
                g = fresh_cells(1'b1);
            end else begin
                g = t_grid'($urandom());
            end
            offer_grid(g, $urandom_range(0, 9) == 0);
        end
        pace_max = 6;
        settle_verdicts();
    endtask

    // Result side back-pressure: random stall after each accepted beat.
    always @(posedge i_clk) begin : sink_pace
        int unsigned hold;
        int unsigned sink_wait;
        if (!i_rst_n) begin
            verdict_out.ready <= 1'b0;
            sink_wait = 0;
        end else if (verdict_out.ready) begin
            if (verdict_out.valid) begin
                hold = $urandom_range(0, pace_max);
                if (hold != 0) begin
                    verdict_out.ready <= 1'b0;
                    sink_wait = hold;
                end
            end
        end else if (sink_wait <= 1) begin
            verdict_out.ready <= 1'b1;
            sink_wait = 0;
        end else begin
            sink_wait--;
        end
    end

    always @(posedge i_clk) begin : verdict_check
        t_verdict want;
        if (i_rst_n && verdict_out.valid && verdict_out.ready) begin
            verdicts_seen++;
            if (verdict_out.table_full) begin
                drops_seen++;
            end
            if (verdicts_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat new=%0b count=%0d full=%0b", $realtime,
                         verdict_out.is_new, verdict_out.stored_count, verdict_out.table_full);
            end else begin
                want = verdicts_due.pop_front();
                if (verdict_out.is_new !== want.is_new) begin
                    errors++;
                    $display("%0t: is_new mismatch, expected %0b actual %0b", $realtime,
                             want.is_new, verdict_out.is_new);
                end
                if (verdict_out.stored_count !== want.stored_count) begin
                    errors++;
                    $display("%0t: stored_count mismatch, expected %0d actual %0d", $realtime,
                             want.stored_count, verdict_out.stored_count);
                end
                if (verdict_out.table_full !== want.table_full) begin
                    errors++;
                    $display("%0t: table_full mismatch, expected %0b actual %0b", $realtime,
                             want.table_full, verdict_out.table_full);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (grid_in.valid && grid_in.ready)
                || (verdict_out.valid && verdict_out.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d results outstanding", $realtime,
                     quiet_cycles, verdicts_due.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        grid_in.valid       <= 1'b0;
        grid_in.grid_cells  <= '0;
        grid_in.clear_first <= 1'b0;
        i_rst_n             <= 1'b0;
        pace_max     = 6;
        feeding      = 1'b0;
        held_total   = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_identity_skipped();
        test_cell_three();
        test_clear_with_grid();
        test_random_mix();

        settle_verdicts();
        repeat (32) @(posedge i_clk);
        $display("Sent %0d grids (%0d with clear), checked %0d results, %0d dropped at full.",
                 grids_sent, clears_sent, verdicts_seen, drops_seen);
        $display("Covered mirror hits, repeated asymmetric grids, cell value three, clears,");
        $display("and idle and stall gaps on both the grid side and the result side.");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/gsd_pkg.sv
sv/gsd_ifaces.sv
sv/gsd_front.sv
sv/gsd_queue.sv
sv/gsd_back.sv
sv/grid_symmetry_dedup_table.sv
sv/gsd_checker.sv
verif/tb_top.sv
